/* rtl/rmsef_pkg.sv */
// shared constants and register codes for the rms envelope follower
package rmsef_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int LEVEL_W           = 16;
  localparam int COEFF_W           = 16;
  localparam int SUM_W             = 44;
  localparam int CNT_W             = 14;
  localparam int MAX_BLOCK_SAMPLES = 8192;
  localparam int SQ_W              = 2 * SAMPLE_W - 1;
  localparam int RAD_W             = 2 * SAMPLE_W;
  localparam int ROOT_STEPS        = SAMPLE_W;
  localparam int MUL_STEPS         = COEFF_W + 1;
  localparam int PROD_W            = LEVEL_W + COEFF_W + 2;
  localparam int STEP_W            = $clog2(SUM_W);
  localparam int APB_DATA_W        = 32;
  localparam int APB_ADDR_W        = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(1) << (SAMPLE_W - 1);

  localparam logic [COEFF_W-1:0] ATTACK_RESET  = 16'd65082;
  localparam logic [COEFF_W-1:0] RELEASE_RESET = 16'd65525;

  localparam logic REG_ATTACK  = 1'b0;
  localparam logic REG_RELEASE = 1'b1;

endpackage

/* rtl/rmsef_in_if.sv */
// sample channel: valid/ready with sample and block mark
interface rmsef_in_if;
  import rmsef_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_of_block;

  modport source (output valid, sample, last_of_block, input ready);
  modport sink   (input valid, sample, last_of_block, output ready);

endinterface

/* rtl/rmsef_out_if.sv */
// result channel: valid/ready with rms level and envelope
interface rmsef_out_if;
  import rmsef_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] rms_level;
  logic [LEVEL_W-1:0] envelope;

  modport source (output valid, rms_level, envelope, input ready);
  modport sink   (input valid, rms_level, envelope, output ready);

endinterface

/* rtl/rms_envelope_follower.sv */
// rms envelope follower top level with bit-serial square, divide, root and smoothing
//
//  channel  | dir | handshake            | payload
//  in_if    | in  | valid/ready          | sample (s16), last_of_block (1)
//  out_if   | out | valid/ready          | rms_level (u16), envelope (u16)
//  apb      | in  | psel/penable/pready  | attack_coeff @0x0, release_coeff @0x4
//
//  a sample without block mark is accepted, squared by the shift-add squarer and
//  accumulated; a marked sample then goes on through the restoring divide, the
//  square root and the multiply steps of the smoothing
//  one sample in flight at a time; a finished beat waits in the output register
//  while the next samples are taken, and only the next result waits on out ready
//  rst_n is synchronous, clears sum, count, envelope and restores the coefficients
module rms_envelope_follower (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rmsef_in_if.sink                             in_if,
  rmsef_out_if.source                          out_if,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rmsef_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rmsef_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rmsef_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);
  import rmsef_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SQUARE,
    ACCUM,
    DIVIDE,
    CLAMP,
    ROOT,
    PREP,
    SMOOTH_EMIT_WAIT
  } state_t;

  localparam logic [SUM_W-1:0]   SUM_LIMIT  = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(MAX_BLOCK_SAMPLES);
  localparam logic [SUM_W-1:0]   MEAN_LIMIT = SUM_W'(1) << (2 * (SAMPLE_W - 1));
  localparam logic [STEP_W-1:0]  SQ_LAST    = STEP_W'(SAMPLE_W - 1);
  localparam logic [STEP_W-1:0]  DIV_LAST   = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0]  ROOT_LAST  = STEP_W'(ROOT_STEPS - 1);
  localparam logic [STEP_W-1:0]  MUL_LAST   = STEP_W'(MUL_STEPS - 1);
  localparam int                 RREM_W     = LEVEL_W + 3;

  state_t                 state_r;
  logic                   mul_done_r;
  logic [STEP_W-1:0]      step_r;
  logic                   last_r;

  logic [COEFF_W-1:0]     attack_r;
  logic [COEFF_W-1:0]     release_r;

  logic [SQ_W-1:0]        mcand_r;
  logic [SAMPLE_W-1:0]    mplier_r;
  logic [SQ_W-1:0]        sq_r;

  logic [SUM_W-1:0]       sum_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       rem_r;

  logic [RAD_W-1:0]       rad_r;
  logic [LEVEL_W-1:0]     root_r;
  logic [RREM_W-1:0]      rrem_r;

  logic [COEFF_W:0]       cmul_r;
  logic [COEFF_W:0]       cinv_r;
  logic [PROD_W-1:0]      env_sh_r;
  logic [PROD_W-1:0]      rms_sh_r;
  logic [PROD_W-1:0]      acc_r;

  logic [LEVEL_W-1:0]     env_r;
  logic                   out_valid_r;
  logic [LEVEL_W-1:0]     out_rms_r;
  logic [LEVEL_W-1:0]     out_env_r;

  logic [SAMPLE_W-1:0]    samp_u;
  logic [SAMPLE_W-1:0]    mag;
  logic [SUM_W:0]         sum_add;
  logic [SUM_W-1:0]       sum_nxt;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [CNT_W:0]         div_trial;
  logic                   div_ge;
  logic [RREM_W+1:0]      root_trial_rem;
  logic [RREM_W+1:0]      root_trial;
  logic                   root_ge;
  logic [COEFF_W-1:0]     coeff_sel;
  logic [PROD_W-1:0]      acc_nxt;
  logic                   apb_wr;
  logic                   out_free;
  logic                   emit;

  assign samp_u  = in_if.sample;
  assign mag     = samp_u[SAMPLE_W-1] ? (~samp_u + SAMPLE_W'(1)) : samp_u;

  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);
  assign sum_nxt = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
  assign cnt_nxt = (cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  assign div_trial = {rem_r, sum_r[SUM_W-1]};
  assign div_ge    = div_trial >= {1'b0, cnt_r};

  assign root_trial_rem = {rrem_r, rad_r[RAD_W-1 -: 2]};
  assign root_trial     = (RREM_W + 2)'({root_r, 2'b01});
  assign root_ge        = root_trial_rem >= root_trial;

  assign coeff_sel = (root_r > env_r) ? attack_r : release_r;

  assign acc_nxt = acc_r + (cmul_r[0] ? env_sh_r : '0) + (cinv_r[0] ? rms_sh_r : '0);

  assign apb_wr   = psel && penable && pwrite;
  assign out_free = !out_valid_r || out_if.ready;
  assign emit     = (state_r == SMOOTH_EMIT_WAIT) && mul_done_r && out_free;

  assign in_if.ready      = (state_r == IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.rms_level = out_rms_r;
  assign out_if.envelope  = out_env_r;

  assign pready = 1'b1;
  assign prdata = APB_DATA_W'((paddr[2] == REG_RELEASE) ? release_r : attack_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      mul_done_r  <= 1'b0;
      step_r      <= '0;
      attack_r    <= ATTACK_RESET;
      release_r   <= RELEASE_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (apb_wr) begin
        unique case (paddr[2])
          REG_ATTACK:  attack_r  <= pwdata[COEFF_W-1:0];
          REG_RELEASE: release_r <= pwdata[COEFF_W-1:0];
          default:     attack_r  <= attack_r;
        endcase
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        IDLE: begin
          if (in_if.valid) begin
            mcand_r  <= SQ_W'(mag);
            mplier_r <= mag;
            sq_r     <= '0;
            last_r   <= in_if.last_of_block;
            step_r   <= '0;
            state_r  <= SQUARE;
          end
        end
        SQUARE: begin
          if (mplier_r[0]) begin
            sq_r <= sq_r + mcand_r;
          end
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          step_r   <= step_r + STEP_W'(1);
          if (step_r == SQ_LAST) begin
            state_r <= ACCUM;
          end
        end
        ACCUM: begin
          sum_r  <= sum_nxt;
          cnt_r  <= cnt_nxt;
          rem_r  <= '0;
          step_r <= '0;
          state_r <= last_r ? DIVIDE : IDLE;
        end
        DIVIDE: begin
          // sum register shifts out dividend bits and takes in quotient bits
          if (div_ge) begin
            rem_r <= CNT_W'(div_trial - {1'b0, cnt_r});
          end else begin
            rem_r <= div_trial[CNT_W-1:0];
          end
          sum_r  <= {sum_r[SUM_W-2:0], div_ge};
          step_r <= step_r + STEP_W'(1);
          if (step_r == DIV_LAST) begin
            state_r <= CLAMP;
          end
        end
        CLAMP: begin
          rad_r   <= (sum_r > MEAN_LIMIT) ? RAD_W'(MEAN_LIMIT) : sum_r[RAD_W-1:0];
          root_r  <= '0;
          rrem_r  <= '0;
          step_r  <= '0;
          state_r <= ROOT;
        end
        ROOT: begin
          if (root_ge) begin
            rrem_r <= RREM_W'(root_trial_rem - root_trial);
            root_r <= {root_r[LEVEL_W-2:0], 1'b1};
          end else begin
            rrem_r <= RREM_W'(root_trial_rem);
            root_r <= {root_r[LEVEL_W-2:0], 1'b0};
          end
          rad_r  <= rad_r << 2;
          step_r <= step_r + STEP_W'(1);
          if (step_r == ROOT_LAST) begin
            state_r <= PREP;
          end
        end
        PREP: begin
          cmul_r     <= (COEFF_W + 1)'(coeff_sel);
          cinv_r     <= ((COEFF_W + 1)'(1) << COEFF_W) - (COEFF_W + 1)'(coeff_sel);
          env_sh_r   <= PROD_W'(env_r);
          rms_sh_r   <= PROD_W'(root_r);
          acc_r      <= '0;
          step_r     <= '0;
          mul_done_r <= 1'b0;
          state_r    <= SMOOTH_EMIT_WAIT;
        end
        SMOOTH_EMIT_WAIT: begin
          if (!mul_done_r) begin
            acc_r    <= acc_nxt;
            env_sh_r <= env_sh_r << 1;
            rms_sh_r <= rms_sh_r << 1;
            cmul_r   <= cmul_r >> 1;
            cinv_r   <= cinv_r >> 1;
            step_r   <= step_r + STEP_W'(1);
            if (step_r == MUL_LAST) begin
              mul_done_r <= 1'b1;
            end
          end else if (out_free) begin
            out_rms_r   <= root_r;
            out_env_r   <= acc_r[COEFF_W +: LEVEL_W];
            env_r       <= acc_r[COEFF_W +: LEVEL_W];
            sum_r       <= '0;
            cnt_r       <= '0;
            mul_done_r  <= 1'b0;
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/rmsef_checker.sv */
// port-level checks for the rms envelope follower and their bind
module rmsef_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rmsef_pkg::LEVEL_W-1:0]     rms_level,
  input logic [rmsef_pkg::LEVEL_W-1:0]     envelope
);
  import rmsef_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(rms_level) && $stable(envelope)))
    else $error("result beat changed while stalled");

  // one sample at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample accepted while busy");

  // levels stay within sample magnitude
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((rms_level <= LEVEL_MAX) && (envelope <= LEVEL_MAX)))
    else $error("level out of range");

  // reset drops the result beat
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rms_envelope_follower rmsef_checker u_rmsef_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .rms_level (out_if.rms_level),
  .envelope  (out_if.envelope)
);

/* dv/tb_rms_envelope_follower.sv */
`timescale 1ns / 1ps
// self-checking testbench for rms_envelope_follower with a block level predictor
module tb_rms_envelope_follower;
  import rmsef_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_block;
  } sample_beat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_level;
    logic [LEVEL_W-1:0] envelope;
  } level_pair_t;

  typedef enum int {FULL_SCALE, QUIET, EXTREMES, HELD} block_shape_t;

  localparam longint unsigned SUM_CEIL    = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned SQUARE_CEIL = 64'd1 << (2 * (SAMPLE_W - 1));
  localparam logic [APB_ADDR_W-1:0] ATTACK_ADDR  = APB_ADDR_W'({REG_ATTACK, 2'b00});
  localparam logic [APB_ADDR_W-1:0] RELEASE_ADDR = APB_ADDR_W'({REG_RELEASE, 2'b00});
  localparam int SETTLE_CYCLES = 120;
  localparam int FULL_SCALE_RUN = 60;
  localparam int RANDOM_RUN = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rmsef_in_if  in_ch ();
  rmsef_out_if out_ch ();

  rms_envelope_follower dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sample_beat_t       sample_q[$];
  level_pair_t        pending_levels[$];
  logic [SUM_W-1:0]   sum_sq;
  logic [CNT_W-1:0]   block_len;
  logic [LEVEL_W-1:0] env_level;
  logic [COEFF_W-1:0] attack_c;
  logic [COEFF_W-1:0] release_c;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 in_taken;
  int                 errors;
  int                 samples_seen;
  int                 blocks_seen;
  int                 settings_used;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic void follow_sample(sample_beat_t beat);
    int              v;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned mean;
    longint unsigned rms;
    longint unsigned coeff;
    longint unsigned next_env;
    level_pair_t     lv;
    v = $signed(beat.sample);
    mag = (v < 0) ? longint'(-v) : longint'(v);
    sq = mag * mag;
    if (64'(sum_sq) > SUM_CEIL - sq) sum_sq = SUM_W'(SUM_CEIL);
    else sum_sq = SUM_W'(64'(sum_sq) + sq);
    if (block_len < MAX_BLOCK_SAMPLES) block_len++;
    if (!beat.last_of_block) return;
    mean = (block_len != 0) ? 64'(sum_sq) / 64'(block_len) : 64'd0;
    if (mean > SQUARE_CEIL) mean = SQUARE_CEIL;
    rms = floor_root(mean);
    coeff = (rms > 64'(env_level)) ? 64'(attack_c) : 64'(release_c);
    next_env = (coeff * 64'(env_level) + (64'd65536 - coeff) * rms) >> 16;
    env_level = LEVEL_W'(next_env);
    lv.rms_level = LEVEL_W'(rms);
    lv.envelope = env_level;
    pending_levels.push_back(lv);
    sum_sq = '0;
    block_len = '0;
    blocks_seen++;
  endfunction

  function automatic void push_sample(logic signed [SAMPLE_W-1:0] s, logic mark);
    sample_beat_t beat;
    beat.sample = s;
    beat.last_of_block = mark;
    sample_q.push_back(beat);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.sample        <= '0;
      in_ch.last_of_block <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid         <= 1'b1;
        in_ch.sample        <= sample_q[0].sample;
        in_ch.last_of_block <= sample_q[0].last_of_block;
        void'(sample_q.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    level_pair_t  lv;
    sample_beat_t beat;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_levels.size() == 0) begin
        errors++;
        $error("result beat with no block pending: rms_level %0d envelope %0d",
               out_ch.rms_level, out_ch.envelope);
      end else begin
        lv = pending_levels.pop_front();
        if (out_ch.rms_level !== lv.rms_level) begin
          errors++;
          $error("rms_level expected %0d actual %0d", lv.rms_level, out_ch.rms_level);
        end
        if (out_ch.envelope !== lv.envelope) begin
          errors++;
          $error("envelope expected %0d actual %0d", lv.envelope, out_ch.envelope);
        end
      end
    end
    if (in_taken) begin
      beat.sample = in_ch.sample;
      beat.last_of_block = in_ch.last_of_block;
      samples_seen++;
      follow_sample(beat);
    end
  end

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_check(input logic [APB_ADDR_W-1:0] addr, input logic [COEFF_W-1:0] want,
                            input string field);
    logic [APB_DATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[COEFF_W-1:0] !== want) begin
      errors++;
      $error("%s expected %0d actual %0d", field, want, rd[COEFF_W-1:0]);
    end
  endtask

  task automatic set_coeffs(input logic [COEFF_W-1:0] att, input logic [COEFF_W-1:0] rel);
    apb_write(ATTACK_ADDR, APB_DATA_W'(att));
    apb_write(RELEASE_ADDR, APB_DATA_W'(rel));
    attack_c  = att;
    release_c = rel;
    read_check(ATTACK_ADDR, att, "attack_coeff");
    read_check(RELEASE_ADDR, rel, "release_coeff");
    settings_used++;
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_ch.valid || pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_blocks(input int n);
    int                         added;
    int                         len;
    int                         pick;
    block_shape_t               shape;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] held;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(8, 1);
      else if (pick < 95) len = $urandom_range(40, 9);
      else len = $urandom_range(120, 41);
      shape = block_shape_t'($urandom_range(3));
      held = SAMPLE_W'($urandom);
      for (int i = 0; i < len; i++) begin
        case (shape)
          FULL_SCALE: s = SAMPLE_W'($urandom);
          QUIET: s = $signed(9'($urandom));
          EXTREMES: begin
            case ($urandom_range(3))
              0: s = 16'sh8000;
              1: s = 16'sh7fff;
              2: s = 16'sh0000;
              default: s = 16'shffff;
            endcase
          end
          default: s = held;
        endcase
        push_sample(s, i == len - 1);
      end
      added += len;
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    sum_sq    = '0;
    block_len = '0;
    env_level = '0;
    attack_c  = ATTACK_RESET;
    release_c = RELEASE_RESET;
    errors        = 0;
    samples_seen  = 0;
    blocks_seen   = 0;
    settings_used = 1;
    send_idle_pct = 9;
    recv_idle_pct = 77;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    read_check(ATTACK_ADDR, ATTACK_RESET, "attack_coeff");
    read_check(RELEASE_ADDR, RELEASE_RESET, "release_coeff");

    // single-sample blocks at the extremes
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh0000, 1'b1);
    push_sample(16'shffff, 1'b1);
    push_sample(16'sh0001, 1'b1);
    // short mixed block
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd100, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd300, 1'b1);
    // full scale with unmarked samples first
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    // silence below the envelope takes the release path; the loud block after it takes the attack path
    push_sample(16'sh0000, 1'b0);
    push_sample(16'sh0000, 1'b1);
    push_sample(16'sh5555, 1'b0);
    push_sample(16'shaaaa, 1'b1);
    queue_random_blocks(520);
    wait_idle();

    set_coeffs(16'd0, 16'd65535);
    send_idle_pct = 77;
    recv_idle_pct = 9;
    queue_random_blocks(520);
    wait_idle();

    set_coeffs(16'd65535, 16'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_blocks(250);
    wait_idle();

    set_coeffs(COEFF_W'($urandom), COEFF_W'($urandom));
    queue_random_blocks(250);
    wait_idle();

    // long full-scale and random blocks
    set_coeffs(16'd0, 16'd0);
    for (int i = 0; i < FULL_SCALE_RUN; i++) push_sample(16'sh8000, i == FULL_SCALE_RUN - 1);
    for (int i = 0; i < RANDOM_RUN; i++) push_sample(SAMPLE_W'($urandom), i == RANDOM_RUN - 1);
    wait_idle();

    $display("ran %0d samples in %0d blocks under %0d coefficient settings",
             samples_seen, blocks_seen, settings_used);
    $display("stalls on either channel, full-scale extremes and long full-scale blocks");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
